// ----- src/bbge_pkg.sv -----
// ----------------------------------------------------------------------------
// bbge_pkg
// Shared types and constants of the three-state cell grid engine.
// ----------------------------------------------------------------------------
`default_nettype none

package bbge_pkg;

    // cell states
    localparam logic [1:0] CELL_OFF   = 2'd0;
    localparam logic [1:0] CELL_ON    = 2'd1;
    localparam logic [1:0] CELL_DYING = 2'd2;
    localparam logic [1:0] CELL_BAD   = 2'd3;

    // item selectors
    typedef enum logic [1:0] {
        ACT_WRITE = 2'd0,
        ACT_RUN   = 2'd1,
        ACT_READ  = 2'd2
    } t_action_e;

    // configuration register indexes
    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_GENS   = 2'd2;

    // result status codes
    localparam logic STATUS_OK    = 1'b0;
    localparam logic STATUS_RANGE = 1'b1;

    // which sides of the center cell lie inside the active area
    typedef struct packed {
        logic up;
        logic down;
        logic left;
        logic right;
    } t_nbr_mask;

endpackage

`default_nettype wire

// ----- src/brians_brain_grid_engine_unit.sv -----
// ----------------------------------------------------------------------------
// brians_brain_grid_engine_unit
// Three-state cell grid with an in-place generation sweep.
// ----------------------------------------------------------------------------
// Input items carry a selector in tuser: write one cell, run the configured
// number of generations, or read one cell. Every item gives exactly one
// result item: the read value in tdata (0 otherwise) and a range flag in
// tuser. A write's result is registered when the item is taken; a read
// passes the registered memory output and a wait state first. A run
// sweeps the grid in raster order, one cell per cycle through a line of
// 2*MAX_COLS+3 shift cells, and stops early once a generation changes
// nothing. The simple dual-port cell memory takes one read and one write
// per cycle. After reset the whole memory is cleared with the input held
// not ready; configuration writes are taken at any time.
// A result waits in an output register while the receiver stalls; the next
// item is taken in the cycle the result leaves.
// ----------------------------------------------------------------------------
`default_nettype none

module brians_brain_grid_engine_unit #(
    parameter int MAX_ROWS = 64,
    parameter int MAX_COLS = 64
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // config write port
    input  wire logic        i_cfg_wr_en,
    input  wire logic  [1:0] i_cfg_index,
    input  wire logic [15:0] i_cfg_wdata,
    // input items
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [15:0] i_s_axis_tdata,   // row[5:0], column[11:6], cell_in[13:12]
    input  wire logic  [1:0] i_s_axis_tuser,   // action[1:0]
    // result items
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic       [7:0] o_m_axis_tdata,   // cell_out[1:0]
    output logic       [0:0] o_m_axis_tuser    // status[0]
);

    import bbge_pkg::*;

    localparam int N      = MAX_ROWS * MAX_COLS;
    localparam int AW     = $clog2(N);
    localparam int LAST   = N + MAX_COLS + 2;
    localparam int CNTW   = $clog2(LAST + 1);
    localparam int CSTART = MAX_COLS + 3;
    localparam int RW     = $clog2(MAX_ROWS);
    localparam int CW     = $clog2(MAX_COLS);
    localparam int HW     = $clog2(MAX_ROWS + 1);
    localparam int WW     = $clog2(MAX_COLS + 1);
    localparam int TAPS   = 2 * MAX_COLS + 3;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RDWAIT,
        ST_RUN
    } t_state_e;

    t_state_e    r_state;
    logic [CNTW-1:0] r_cnt;
    logic [RW-1:0]   r_crow;
    logic [CW-1:0]   r_ccol;
    logic [AW-1:0]   r_cidx;
    logic            r_chg;
    logic [15:0]     r_gen_left;
    logic            r_qv;
    logic            r_out_valid;
    logic [1:0]      r_out_cell;
    logic            r_out_status;
    logic [6:0]      r_cfg_w;
    logic [6:0]      r_cfg_h;
    logic [15:0]     r_cfg_gens;

    logic [1:0]      r_mem [N];
    logic [1:0]      r_mem_q;

    logic [HW-1:0]   h_use;
    logic [WW-1:0]   w_use;
    logic [5:0]      in_row;
    logic [5:0]      in_col;
    logic [1:0]      in_cell;
    t_action_e       in_act;
    logic            in_accept;
    logic            coord_bad;
    logic [AW-1:0]   item_addr;

    logic            mem_we;
    logic [AW-1:0]   mem_wa;
    logic [1:0]      mem_wd;
    logic [AW-1:0]   mem_ra;

    logic [1:0]      tap_in;
    logic [1:0]      w_tap [TAPS];
    logic [7:0][1:0] w_nbr;
    t_nbr_mask       w_mask;
    logic [1:0]      w_cur;
    logic [1:0]      w_nxt;
    logic            center_act;
    logic            in_area;
    logic            run_we;
    logic            changed_now;
    logic            run_shift;

    // clamp the size registers to the usable range
    always_comb begin
        if (r_cfg_h == 7'd0) begin
            h_use = HW'(1);
        end else if (32'(r_cfg_h) > MAX_ROWS) begin
            h_use = HW'(MAX_ROWS);
        end else begin
            h_use = HW'(r_cfg_h);
        end
        if (r_cfg_w == 7'd0) begin
            w_use = WW'(1);
        end else if (32'(r_cfg_w) > MAX_COLS) begin
            w_use = WW'(MAX_COLS);
        end else begin
            w_use = WW'(r_cfg_w);
        end
    end

    // item decode
    assign in_row    = i_s_axis_tdata[5:0];
    assign in_col    = i_s_axis_tdata[11:6];
    assign in_cell   = i_s_axis_tdata[13:12];
    assign in_act    = t_action_e'(i_s_axis_tuser);
    assign coord_bad = (32'(in_row) >= 32'(h_use)) || (32'(in_col) >= 32'(w_use));
    assign item_addr = AW'(32'(in_row) * MAX_COLS + 32'(in_col));

    assign o_s_axis_tready = (r_state == ST_IDLE) && (!r_out_valid || i_m_axis_tready);
    assign in_accept       = i_s_axis_tvalid && o_s_axis_tready;

    // window line
    assign run_shift = (r_state == ST_RUN);
    assign tap_in    = r_qv ? r_mem_q : CELL_OFF;

    for (genvar t = 0; t < TAPS; t++) begin : g_line
        if (t == 0) begin : g_head
            bbge_cell u_cell (
                .i_clk  (i_clk),
                .i_shift(run_shift),
                .i_d    (tap_in),
                .o_q    (w_tap[t])
            );
        end else begin : g_body
            bbge_cell u_cell (
                .i_clk  (i_clk),
                .i_shift(run_shift),
                .i_d    (w_tap[t-1]),
                .o_q    (w_tap[t])
            );
        end
    end

    // window taps around the center cell
    assign w_cur = w_tap[MAX_COLS+1];
    assign w_nbr = {w_tap[0], w_tap[1], w_tap[2],
                    w_tap[MAX_COLS], w_tap[MAX_COLS+2],
                    w_tap[2*MAX_COLS], w_tap[2*MAX_COLS+1], w_tap[2*MAX_COLS+2]};

    assign w_mask.up    = (r_crow != '0);
    assign w_mask.down  = (32'(r_crow) + 32'd1) < 32'(h_use);
    assign w_mask.left  = (r_ccol != '0);
    assign w_mask.right = (32'(r_ccol) + 32'd1) < 32'(w_use);

    bbge_rule u_rule (
        .i_cur (w_cur),
        .i_nbr (w_nbr),
        .i_mask(w_mask),
        .o_nxt (w_nxt)
    );

    assign center_act  = (r_state == ST_RUN) && (32'(r_cnt) >= CSTART);
    assign in_area     = (32'(r_crow) < 32'(h_use)) && (32'(r_ccol) < 32'(w_use));
    assign run_we      = center_act && in_area;
    assign changed_now = run_we && (w_nxt != w_cur);

    // memory port control
    always_comb begin
        mem_we = 1'b0;
        mem_wa = item_addr;
        mem_wd = (in_cell == CELL_BAD) ? CELL_OFF : in_cell;
        mem_ra = item_addr;
        unique case (r_state)
            ST_CLEAR: begin
                mem_we = 1'b1;
                mem_wa = AW'(r_cnt);
                mem_wd = CELL_OFF;
            end
            ST_IDLE: begin
                mem_we = in_accept && (in_act == ACT_WRITE) && !coord_bad;
            end
            ST_RUN: begin
                mem_we = run_we;
                mem_wa = r_cidx;
                mem_wd = w_nxt;
                mem_ra = AW'(r_cnt);
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    // cell memory
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        r_mem_q <= r_mem[mem_ra];
    end

    // control and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_CLEAR;
            r_cnt        <= '0;
            r_crow       <= '0;
            r_ccol       <= '0;
            r_cidx       <= '0;
            r_chg        <= 1'b0;
            r_gen_left   <= '0;
            r_qv         <= 1'b0;
            r_out_valid  <= 1'b0;
            r_out_cell   <= CELL_OFF;
            r_out_status <= STATUS_OK;
            r_cfg_w      <= 7'd64;
            r_cfg_h      <= 7'd64;
            r_cfg_gens   <= 16'd1;
        end else begin
            // config writes
            if (i_cfg_wr_en) begin
                unique case (i_cfg_index)
                    REG_WIDTH:  r_cfg_w    <= i_cfg_wdata[6:0];
                    REG_HEIGHT: r_cfg_h    <= i_cfg_wdata[6:0];
                    REG_GENS:   r_cfg_gens <= i_cfg_wdata;
                    default:    ;
                endcase
            end

            r_qv <= (r_state == ST_RUN) && (32'(r_cnt) < N);

            if (r_out_valid && i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                ST_CLEAR: begin
                    if (32'(r_cnt) == N - 1) begin
                        r_cnt   <= '0;
                        r_state <= ST_IDLE;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                ST_IDLE: begin
                    if (in_accept) begin
                        r_out_cell   <= CELL_OFF;
                        r_out_status <= STATUS_OK;
                        unique case (in_act)
                            ACT_WRITE: begin
                                r_out_valid  <= 1'b1;
                                r_out_status <= coord_bad ? STATUS_RANGE : STATUS_OK;
                            end
                            ACT_READ: begin
                                if (coord_bad) begin
                                    r_out_valid  <= 1'b1;
                                    r_out_status <= STATUS_RANGE;
                                end else begin
                                    r_state <= ST_RDWAIT;
                                end
                            end
                            ACT_RUN: begin
                                if (r_cfg_gens == 16'd0) begin
                                    r_out_valid <= 1'b1;
                                end else begin
                                    r_state    <= ST_RUN;
                                    r_cnt      <= '0;
                                    r_crow     <= '0;
                                    r_ccol     <= '0;
                                    r_cidx     <= '0;
                                    r_chg      <= 1'b0;
                                    r_gen_left <= r_cfg_gens;
                                end
                            end
                            default: begin
                                r_out_valid <= 1'b1;
                            end
                        endcase
                    end
                end
                ST_RDWAIT: begin
                    r_out_valid  <= 1'b1;
                    r_out_cell   <= r_mem_q;
                    r_out_status <= STATUS_OK;
                    r_state      <= ST_IDLE;
                end
                ST_RUN: begin
                    // center position walks the grid in raster order
                    if (center_act) begin
                        r_cidx <= r_cidx + 1'b1;
                        if (32'(r_ccol) == MAX_COLS - 1) begin
                            r_ccol <= '0;
                            r_crow <= r_crow + 1'b1;
                        end else begin
                            r_ccol <= r_ccol + 1'b1;
                        end
                    end
                    if (32'(r_cnt) == LAST) begin
                        if (!(r_chg || changed_now) || (r_gen_left == 16'd1)) begin
                            r_state      <= ST_IDLE;
                            r_out_valid  <= 1'b1;
                            r_out_cell   <= CELL_OFF;
                            r_out_status <= STATUS_OK;
                        end else begin
                            r_cnt      <= '0;
                            r_crow     <= '0;
                            r_ccol     <= '0;
                            r_cidx     <= '0;
                            r_chg      <= 1'b0;
                            r_gen_left <= r_gen_left - 1'b1;
                        end
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                        r_chg <= r_chg || changed_now;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {6'b000000, r_out_cell};
    assign o_m_axis_tuser  = r_out_status;

`ifndef SYNTH
    // no item taken while a result is stuck in the output register
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_axis_tready |-> (!r_out_valid || i_m_axis_tready))
        else $error("item accepted while result slot full");

    // sweep writes stay inside the active area
    a_run_in_area: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RUN && mem_we) |->
            ((32'(r_crow) < 32'(h_use)) && (32'(r_ccol) < 32'(w_use))))
        else $error("sweep wrote outside active area");

    // read data returns into a free result slot
    a_rd_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RDWAIT) |-> !r_out_valid)
        else $error("read result with result slot full");
`endif

endmodule

`default_nettype wire

// ----- src/bbge_cell.sv -----
// ----------------------------------------------------------------------------
// bbge_cell
// One stage of the window line: holds one cell value and hands it on.
// ----------------------------------------------------------------------------
`default_nettype none

module bbge_cell (
    input  wire logic       i_clk,
    input  wire logic       i_shift,
    input  wire logic [1:0] i_d,
    output logic      [1:0] o_q
);

    logic [1:0] r_q;

    // shift stage
    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_q <= i_d;
        end
    end

    assign o_q = r_q;

endmodule

`default_nettype wire

// ----- src/bbge_rule.sv -----
// ----------------------------------------------------------------------------
// bbge_rule
// Next-state rule for one cell from its 3x3 window.
// ----------------------------------------------------------------------------
`default_nettype none

module bbge_rule (
    input  wire logic            [1:0] i_cur,
    // neighbors: nw, n, ne, w, e, sw, s, se
    input  wire logic       [7:0][1:0] i_nbr,
    input  wire bbge_pkg::t_nbr_mask   i_mask,
    output logic                 [1:0] o_nxt
);

    import bbge_pkg::*;

    logic [7:0] w_valid;
    logic [3:0] w_on_cnt;

    // neighbor validity from the sides in range
    assign w_valid = {i_mask.down & i_mask.right, i_mask.down, i_mask.down & i_mask.left,
                      i_mask.right, i_mask.left,
                      i_mask.up & i_mask.right, i_mask.up, i_mask.up & i_mask.left};

    // count live neighbors
    always_comb begin
        w_on_cnt = 4'd0;
        for (int i = 0; i < 8; i++) begin
            w_on_cnt = w_on_cnt + {3'b000, (w_valid[i] && (i_nbr[i] == CELL_ON))};
        end
    end

    // on goes dying, dying goes off, off turns on with exactly two live neighbors
    always_comb begin
        unique case (i_cur)
            CELL_ON:    o_nxt = CELL_DYING;
            CELL_DYING: o_nxt = CELL_OFF;
            default:    o_nxt = (w_on_cnt == 4'd2) ? CELL_ON : CELL_OFF;
        endcase
    end

endmodule

`default_nettype wire
